// File: hw/rtl/blr_pkg.sv
// blr_pkg: shared constants and types for the line rasteriser.
// No dependencies; imported by blr_step, the top level and blr_checker.
package blr_pkg;

  localparam int ADDR_BITS   = 28;
  localparam int COLOR_BITS  = 8;
  localparam int STRIDE_BITS = 16;
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 2;

  localparam logic [STRIDE_BITS-1:0] ROW_STRIDE_RESET = 16'd16384;

  // register byte addresses
  localparam logic [APB_ADDR_BITS-1:0] REG_ROW_STRIDE = 2'd0;

  // item modes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  // per-line direction and status flags
  typedef struct packed {
    logic active;
    logic col_negative;
    logic row_negative;
    logic col_major;
  } line_ctrl_t;

endpackage

// File: hw/rtl/blr_step.sv
// blr_step: combinational Bresenham setup and single-step update.
// Depends on blr_pkg (line_ctrl_t, mode codes).
module blr_step
  import blr_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                  mode,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  input  logic [COORD_BITS-1:0] cur_col,
  input  logic [COORD_BITS-1:0] cur_row,
  input  logic [COORD_BITS-1:0] target_major,
  input  logic [COORD_BITS:0]   twice_major_delta,
  input  logic [COORD_BITS:0]   twice_minor_delta,
  input  logic signed [COORD_BITS+2:0] error_balance,
  input  line_ctrl_t            ctrl,
  output logic                  emit,
  output logic                  last,
  output logic [COORD_BITS-1:0] cur_col_next,
  output logic [COORD_BITS-1:0] cur_row_next,
  output logic [COORD_BITS-1:0] target_major_next,
  output logic [COORD_BITS:0]   twice_major_delta_next,
  output logic [COORD_BITS:0]   twice_minor_delta_next,
  output logic signed [COORD_BITS+2:0] error_balance_next,
  output line_ctrl_t            ctrl_next
);

  localparam int EB = COORD_BITS + 3;

  logic                  col_neg, row_neg, col_major_s;
  logic [COORD_BITS-1:0] dx, dy, dmaj, dmin;
  logic [COORD_BITS-1:0] step_col, step_row, major;
  logic                  minor_move;
  logic signed [EB-1:0]  err_sub;

  always_comb begin
    // line setup
    col_neg     = end_x < start_x;
    row_neg     = end_y < start_y;
    dx          = col_neg ? start_x - end_x : end_x - start_x;
    dy          = row_neg ? start_y - end_y : end_y - start_y;
    col_major_s = dx >= dy;
    dmaj        = col_major_s ? dx : dy;
    dmin        = col_major_s ? dy : dx;

    // one step along the major axis, minor axis when the balance is non-negative
    minor_move = !error_balance[EB-1];
    step_col   = ctrl.col_negative ? cur_col - 1'b1 : cur_col + 1'b1;
    step_row   = ctrl.row_negative ? cur_row - 1'b1 : cur_row + 1'b1;
    err_sub    = minor_move ? $signed({2'b00, twice_major_delta}) : '0;

    ctrl_next              = ctrl;
    cur_col_next           = cur_col;
    cur_row_next           = cur_row;
    target_major_next      = target_major;
    twice_major_delta_next = twice_major_delta;
    twice_minor_delta_next = twice_minor_delta;
    error_balance_next     = error_balance;
    emit                   = 1'b0;

    if (mode == MODE_START) begin
      emit                   = 1'b1;
      ctrl_next.col_negative = col_neg;
      ctrl_next.row_negative = row_neg;
      ctrl_next.col_major    = col_major_s;
      cur_col_next           = start_x;
      cur_row_next           = start_y;
      target_major_next      = col_major_s ? end_x : end_y;
      twice_major_delta_next = {dmaj, 1'b0};
      twice_minor_delta_next = {dmin, 1'b0};
      error_balance_next     = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
    end else if (ctrl.active) begin
      emit = 1'b1;
      if (ctrl.col_major) begin
        cur_col_next = step_col;
        cur_row_next = minor_move ? step_row : cur_row;
      end else begin
        cur_row_next = step_row;
        cur_col_next = minor_move ? step_col : cur_col;
      end
      error_balance_next = error_balance - err_sub
                         + $signed({2'b00, twice_minor_delta});
    end

    major = ctrl_next.col_major ? cur_col_next : cur_row_next;
    last  = major == target_major_next;
    if (emit) begin
      ctrl_next.active = !last;
    end
  end

endmodule

// File: hw/rtl/bresenham_line_rasterizer_unit.sv
// bresenham_line_rasterizer_unit: top level of the Bresenham line rasteriser.
// Depends on blr_pkg and blr_step.
//
// Usage
//   Item channel (item_valid / item_stall): one word per line command. A word
//   with mode 0 starts a line from (start_x, start_y) to (end_x, end_y) in the
//   given colour; mode 1 asks for the next pixel of the current line. A step
//   word while no line is active is taken and produces nothing; a start word
//   during a line drops the old line.
//   Pixel channel (pixel_valid / pixel_stall): one word per pixel with its
//   byte address row*row_stride + col*4 (low 28 bits), its coordinates, the
//   BGRA bytes and last_pixel on the line's final endpoint.
//   APB port: row_stride at byte address 0; the user must write it only while idle, as the block has no check for this.
// Timing
//   One word accepted per cycle while pixel_stall is low. The step
//   stage (add and compare on the line state) registers the pixel, then the
//   address stage (one row*stride multiply) registers the output word.
// Reset
//   rst (synchronous) empties both stages, marks no line active and loads
//   row_stride with 16384.
// Stall
//   While pixel_stall is high the output word holds; the step stage still
//   takes one more word, after which item_stall rises until the output moves.
module bresenham_line_rasterizer_unit
  import blr_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  // item channel
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic                     mode,
  input  logic [COORD_BITS-1:0]    start_x,
  input  logic [COORD_BITS-1:0]    start_y,
  input  logic [COORD_BITS-1:0]    end_x,
  input  logic [COORD_BITS-1:0]    end_y,
  input  logic [COLOR_BITS-1:0]    color_red,
  input  logic [COLOR_BITS-1:0]    color_green,
  input  logic [COLOR_BITS-1:0]    color_blue,
  input  logic [COLOR_BITS-1:0]    color_alpha,
  // pixel channel
  output logic                     pixel_valid,
  input  logic                     pixel_stall,
  output logic [ADDR_BITS-1:0]     pixel_address,
  output logic [COORD_BITS-1:0]    pixel_x,
  output logic [COORD_BITS-1:0]    pixel_y,
  output logic [COLOR_BITS-1:0]    out_blue,
  output logic [COLOR_BITS-1:0]    out_green,
  output logic [COLOR_BITS-1:0]    out_red,
  output logic [COLOR_BITS-1:0]    out_alpha,
  output logic                     last_pixel,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int EB = COORD_BITS + 3;
  // wide enough for row*stride + col*4 and for the address field
  localparam int SUM_BITS = (COORD_BITS + STRIDE_BITS + 1 > ADDR_BITS)
                          ? COORD_BITS + STRIDE_BITS + 1 : ADDR_BITS;

  // configuration
  logic [STRIDE_BITS-1:0] row_stride;

  // line state
  line_ctrl_t             ctrl, ctrl_next;
  logic [COORD_BITS-1:0]  cur_col, cur_col_next;
  logic [COORD_BITS-1:0]  cur_row, cur_row_next;
  logic [COORD_BITS-1:0]  target_major, target_major_next;
  logic [COORD_BITS:0]    twice_major_delta, twice_major_delta_next;
  logic [COORD_BITS:0]    twice_minor_delta, twice_minor_delta_next;
  logic signed [EB-1:0]   error_balance, error_balance_next;
  logic [COLOR_BITS-1:0]  held_red, held_green, held_blue, held_alpha;
  logic [COLOR_BITS-1:0]  red_next, green_next, blue_next, alpha_next;

  // step stage
  logic                   a_valid;
  logic [COORD_BITS-1:0]  a_x, a_y;
  logic [COLOR_BITS-1:0]  a_red, a_green, a_blue, a_alpha;
  logic                   a_last;

  logic                   emit, last;
  logic                   accept, b_load;
  logic [SUM_BITS-1:0]    addr_sum;

  // APB: always ready, single register
  assign pready = 1'b1;
  assign prdata = APB_DATA_BITS'(row_stride);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_stride <= ROW_STRIDE_RESET;
    end else if (psel && penable && pwrite && paddr == REG_ROW_STRIDE) begin
      row_stride <= pwdata[STRIDE_BITS-1:0];
    end
  end

  // Handshake: the output register loads when empty or draining; the step
  // stage takes a word when it is empty or moving on.
  assign b_load     = !pixel_valid || !pixel_stall;
  assign item_stall = a_valid && !b_load;
  assign accept     = item_valid && !item_stall;

  blr_step #(
    .COORD_BITS(COORD_BITS)
  ) u_step (
    .mode                   (mode),
    .start_x                (start_x),
    .start_y                (start_y),
    .end_x                  (end_x),
    .end_y                  (end_y),
    .cur_col                (cur_col),
    .cur_row                (cur_row),
    .target_major           (target_major),
    .twice_major_delta      (twice_major_delta),
    .twice_minor_delta      (twice_minor_delta),
    .error_balance          (error_balance),
    .ctrl                   (ctrl),
    .emit                   (emit),
    .last                   (last),
    .cur_col_next           (cur_col_next),
    .cur_row_next           (cur_row_next),
    .target_major_next      (target_major_next),
    .twice_major_delta_next (twice_major_delta_next),
    .twice_minor_delta_next (twice_minor_delta_next),
    .error_balance_next     (error_balance_next),
    .ctrl_next              (ctrl_next)
  );

  // a start word brings a new colour, a step keeps the held one
  always_comb begin
    if (mode == MODE_START) begin
      red_next   = color_red;
      green_next = color_green;
      blue_next  = color_blue;
      alpha_next = color_alpha;
    end else begin
      red_next   = held_red;
      green_next = held_green;
      blue_next  = held_blue;
      alpha_next = held_alpha;
    end
  end

  // line state: only the control flags get a reset, a start loads the rest
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else if (accept) begin
      ctrl <= ctrl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_col           <= cur_col_next;
      cur_row           <= cur_row_next;
      target_major      <= target_major_next;
      twice_major_delta <= twice_major_delta_next;
      twice_minor_delta <= twice_minor_delta_next;
      error_balance     <= error_balance_next;
      held_red          <= red_next;
      held_green        <= green_next;
      held_blue         <= blue_next;
      held_alpha        <= alpha_next;
    end
  end

  // step stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= emit;
    end else if (b_load) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_x     <= cur_col_next;
      a_y     <= cur_row_next;
      a_red   <= red_next;
      a_green <= green_next;
      a_blue  <= blue_next;
      a_alpha <= alpha_next;
      a_last  <= last;
    end
  end

  // address stage: one multiply, wrap to the address width
  assign addr_sum = SUM_BITS'(a_y) * SUM_BITS'(row_stride)
                  + SUM_BITS'({a_x, 2'b00});

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (b_load) begin
      pixel_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      pixel_address <= addr_sum[ADDR_BITS-1:0];
      pixel_x       <= a_x;
      pixel_y       <= a_y;
      out_blue      <= a_blue;
      out_green     <= a_green;
      out_red       <= a_red;
      out_alpha     <= a_alpha;
      last_pixel    <= a_last;
    end
  end

endmodule

// File: hw/rtl/blr_checker.sv
// blr_checker: port-level assertions for the line rasteriser, bound to the top.
// Depends on blr_pkg and bresenham_line_rasterizer_unit.
module blr_checker
  import blr_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     item_valid,
  input logic                     item_stall,
  input logic                     pixel_valid,
  input logic                     pixel_stall,
  input logic [ADDR_BITS-1:0]     pixel_address,
  input logic [COORD_BITS-1:0]    pixel_x,
  input logic [COORD_BITS-1:0]    pixel_y,
  input logic                     last_pixel,
  input logic                     psel,
  input logic                     penable,
  input logic                     pwrite,
  input logic [APB_ADDR_BITS-1:0] paddr,
  input logic [APB_DATA_BITS-1:0] pwdata
);

  localparam int SUM_BITS = (COORD_BITS + STRIDE_BITS + 1 > ADDR_BITS)
                          ? COORD_BITS + STRIDE_BITS + 1 : ADDR_BITS;

  logic [STRIDE_BITS-1:0] shadow_stride;
  logic [SUM_BITS-1:0]    expect_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      shadow_stride <= ROW_STRIDE_RESET;
    end else if (psel && penable && pwrite && paddr == REG_ROW_STRIDE) begin
      shadow_stride <= pwdata[STRIDE_BITS-1:0];
    end
  end

  assign expect_sum = SUM_BITS'(pixel_y) * SUM_BITS'(shadow_stride)
                    + SUM_BITS'({pixel_x, 2'b00});

  // a held output word keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel_address)
      && $stable(pixel_x) && $stable(pixel_y) && $stable(last_pixel))
    else $error("stalled pixel word changed");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !pixel_valid)
    else $error("pixel word valid after reset");

  // the input only backs up behind a full, stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> pixel_valid && pixel_stall)
    else $error("item channel stalled with output free");

  // address agrees with the coordinates and the programmed stride
  a_address: assert property (@(posedge clk) disable iff (rst)
    pixel_valid |-> pixel_address == expect_sum[ADDR_BITS-1:0])
    else $error("pixel address mismatch");

  // straight after reset an offered item word is never held off
  a_item_stall_reset: assert property (@(posedge clk)
    rst |=> !item_stall || !item_valid || pixel_valid)
    else $error("item stalled straight after reset");

endmodule

bind bresenham_line_rasterizer_unit blr_checker #(
  .COORD_BITS(COORD_BITS)
) u_blr_checker (.*);
